### rtl/brle_pkg.sv
// Shared types and constants for the binary run-length encoder.
package brle_pkg;

    localparam int CodeW      = 16;
    localparam int GammaW     = 5;
    localparam int GammaReset = 8;
    localparam int RecWords   = 3;
    localparam int QDepth     = 4;
    localparam int QPtrW      = $clog2(QDepth);
    localparam int QCntW      = $clog2(QDepth + 1);

    localparam logic KindHeader = 1'b0;
    localparam logic KindRun    = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [CodeW-1:0] value;
        logic             last;
    } word_t;

    // words[0] goes out first
    typedef struct packed {
        logic [1:0]               count;
        word_t [RecWords-1:0]     words;
    } rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

### rtl/brle_front.sv
// Front end: takes bit beats, tracks the run and builds one record of words per bit.
module brle_front #(
    parameter int GAMMA_CAP = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         bit_value,
    input  logic                         end_of_stream,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [brle_pkg::GammaW-1:0]  gamma_bits,
    input  brle_pkg::fifo_stat_t         q_stat,
    output logic                         push,
    output brle_pkg::rec_t               push_rec
);

    localparam int ResetG = (brle_pkg::GammaReset < GAMMA_CAP) ? brle_pkg::GammaReset
                                                                 : GAMMA_CAP;
    localparam logic [brle_pkg::CodeW-1:0] ResetM =
        brle_pkg::CodeW'((64'd1 << ResetG) - 64'd1);

    logic                       started_reg, started_next;
    logic                       cur_reg, cur_next;
    logic [brle_pkg::CodeW-1:0] run_reg, run_next;
    logic [brle_pkg::CodeW-1:0] m_reg, m_next;
    logic [brle_pkg::GammaW-1:0] g_clamp;
    logic [brle_pkg::CodeW-1:0] old_sat;
    logic [brle_pkg::CodeW-1:0] fin_sat;
    logic [1:0]                 n;
    logic                       in_fire;
    brle_pkg::word_t            fin_word;

    assign in_ready  = !q_stat.full;
    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && in_ready;

    always_comb
    begin
        g_clamp = gamma_bits;
        if (g_clamp == '0)
        begin
            g_clamp = brle_pkg::GammaW'(1);
        end
        if (g_clamp > brle_pkg::GammaW'(GAMMA_CAP))
        begin
            g_clamp = brle_pkg::GammaW'(GAMMA_CAP);
        end
        m_next = m_reg;
        if (cfg_valid)
        begin
            m_next = brle_pkg::CodeW'((17'd1 << g_clamp) - 17'd1);
        end
    end

    assign old_sat = (run_reg > m_reg) ? m_reg : run_reg;

    always_comb
    begin
        started_next = started_reg;
        cur_next     = cur_reg;
        run_next     = run_reg;
        push_rec     = '0;
        n            = 2'd0;
        fin_sat      = '0;
        fin_word     = '0;
        if (in_fire)
        begin
            priority if (!started_reg)
            begin
                push_rec.words[0] = '{kind: brle_pkg::KindHeader,
                                      value: brle_pkg::CodeW'(bit_value), last: 1'b0};
                n            = 2'd1;
                started_next = 1'b1;
                cur_next     = bit_value;
                run_next     = brle_pkg::CodeW'(1);
            end
            else if (bit_value == cur_reg)
            begin
                if (run_reg >= m_reg)
                begin
                    push_rec.words[0] = '{kind: brle_pkg::KindRun, value: m_reg, last: 1'b0};
                    push_rec.words[1] = '{kind: brle_pkg::KindRun, value: '0, last: 1'b0};
                    n        = 2'd2;
                    run_next = brle_pkg::CodeW'(1);
                end
                else
                begin
                    run_next = run_reg + brle_pkg::CodeW'(1);
                end
            end
            else
            begin
                push_rec.words[0] = '{kind: brle_pkg::KindRun, value: old_sat, last: 1'b0};
                n        = 2'd1;
                cur_next = bit_value;
                run_next = brle_pkg::CodeW'(1);
            end

            if (end_of_stream)
            begin
                fin_sat  = (run_next > m_reg) ? m_reg : run_next;
                fin_word = '{kind: brle_pkg::KindRun, value: fin_sat, last: 1'b1};
                unique case (n)
                    2'd0:    push_rec.words[0] = fin_word;
                    2'd1:    push_rec.words[1] = fin_word;
                    default: push_rec.words[2] = fin_word;
                endcase
                n            = n + 2'd1;
                started_next = 1'b0;
                cur_next     = 1'b0;
                run_next     = '0;
            end
        end
        push_rec.count = n;
    end

    assign push = in_fire && (n != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            cur_reg     <= 1'b0;
            run_reg     <= '0;
            m_reg       <= ResetM;
        end
        else
        begin
            started_reg <= started_next;
            cur_reg     <= cur_next;
            run_reg     <= run_next;
            m_reg       <= m_next;
        end
    end

endmodule

### rtl/brle_fifo.sv
// Short record queue between front and back end.
module brle_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  brle_pkg::rec_t       push_rec,
    input  logic                 pop,
    output brle_pkg::rec_t       head,
    output brle_pkg::fifo_stat_t stat
);

    brle_pkg::rec_t mem [brle_pkg::QDepth];

    logic [brle_pkg::QPtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [brle_pkg::QPtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [brle_pkg::QCntW-1:0] cnt_reg, cnt_next;

    assign stat.full  = (cnt_reg == brle_pkg::QCntW'(brle_pkg::QDepth));
    assign stat.empty = (cnt_reg == '0);
    assign head       = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + (push ? brle_pkg::QPtrW'(1) : '0);
        rd_ptr_next = rd_ptr_reg + (pop ? brle_pkg::QPtrW'(1) : '0);
        cnt_next    = cnt_reg + (push ? brle_pkg::QCntW'(1) : '0)
                              - (pop ? brle_pkg::QCntW'(1) : '0);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

### rtl/brle_back.sv
// Back end: walks the head record one word a cycle, unless stalled, into the output register.
module brle_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  brle_pkg::rec_t             head,
    input  brle_pkg::fifo_stat_t       q_stat,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       word_kind,
    output logic [brle_pkg::CodeW-1:0] code_value,
    output logic                       final_word
);

    logic            valid_reg, valid_next;
    logic [1:0]      sub_reg, sub_next;
    brle_pkg::word_t word_reg, word_next;
    logic            load;
    logic            rec_done;

    assign load     = !q_stat.empty && (!valid_reg || out_ready);
    assign rec_done = (sub_reg == (head.count - 2'd1));
    assign pop      = load && rec_done;

    always_comb
    begin
        valid_next = valid_reg;
        sub_next   = sub_reg;
        word_next  = word_reg;
        if (load)
        begin
            valid_next = 1'b1;
            word_next  = head.words[sub_reg];
            sub_next   = rec_done ? 2'd0 : sub_reg + 2'd1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sub_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            sub_reg   <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign out_valid  = valid_reg;
    assign word_kind  = word_reg.kind;
    assign code_value = word_reg.value;
    assign final_word = word_reg.last;

endmodule

### rtl/binary_run_length_encoder.sv
// Binary run-length encoder top level: front end, record queue, back end.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------
//  in       | in_valid / in_ready   | bit_value, end_of_stream
//  out      | out_valid / out_ready | word_kind, code_value, final_word
//  cfg      | cfg_valid / cfg_ready | gamma_bits (always ready)
//
//  One bit beat a cycle while the four-record queue has room; each beat yields
//  a record of zero to three words, drained one word a cycle by the back end
//  unless out_ready stalls it, so escape records (two or three words) cost
//  extra output cycles. in_ready drops only when the queue is full. Reset:
//  asynchronous, active low; no clearing pass.
module binary_run_length_encoder #(
    parameter int MAX_GAMMA = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       bit_value,
    input  logic                       end_of_stream,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       word_kind,
    output logic [brle_pkg::CodeW-1:0] code_value,
    output logic                       final_word,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [brle_pkg::GammaW-1:0] gamma_bits
);

    localparam int GammaCap = (MAX_GAMMA < brle_pkg::CodeW) ? MAX_GAMMA : brle_pkg::CodeW;

    brle_pkg::fifo_stat_t q_stat;
    brle_pkg::rec_t       push_rec;
    brle_pkg::rec_t       head;
    logic                 push;
    logic                 pop;

    brle_front #(
        .GAMMA_CAP (GammaCap)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .bit_value     (bit_value),
        .end_of_stream (end_of_stream),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .gamma_bits    (gamma_bits),
        .q_stat        (q_stat),
        .push          (push),
        .push_rec      (push_rec)
    );

    brle_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .head     (head),
        .stat     (q_stat)
    );

    brle_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .q_stat     (q_stat),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .word_kind  (word_kind),
        .code_value (code_value),
        .final_word (final_word)
    );

endmodule

### rtl/brle_checker.sv
// Port-level checks for the binary run-length encoder, bound to the top level.
module brle_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic                       word_kind,
    input logic [brle_pkg::CodeW-1:0] code_value,
    input logic                       final_word
);

    // header carries a single bit and never closes a stream
    a_header_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (word_kind == brle_pkg::KindHeader)
        |-> (code_value[brle_pkg::CodeW-1:1] == '0) && !final_word)
        else $error("header beat malformed");

    // the word after a final word opens a new stream
    a_header_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && final_word
        |=> !out_valid || (word_kind == brle_pkg::KindHeader))
        else $error("new stream without header");

    // stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready
        |=> out_valid && $stable(word_kind) && $stable(code_value) && $stable(final_word))
        else $error("output beat changed under stall");

endmodule

bind binary_run_length_encoder brle_checker u_brle_checker (.*);

### sim/tb_binary_run_length_encoder.sv
// Testbench for binary_run_length_encoder: directed table, random runs, word-by-word checks.
`timescale 1ns / 100ps

module tb_binary_run_length_encoder;

    localparam int MaxGamma    = 16;
    localparam int IdlePct     = 37;
    localparam int HoldCycles  = 80;
    localparam int DrainCycles = 6;
    localparam int CycleLimit  = 200_000;
    localparam int PhaseBeats  = 42;
    localparam int RandPhases  = 12;

    localparam logic Hdr = brle_pkg::KindHeader;
    localparam logic Run = brle_pkg::KindRun;

    localparam brle_pkg::word_t NoWord = '0;

    typedef struct packed {
        logic [brle_pkg::GammaW-1:0] gamma;
        logic                        bv;
        logic                        eos;
        brle_pkg::rec_t              want;
    } row_t;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    logic                        bit_value;
    logic                        end_of_stream;
    logic                        out_valid;
    logic                        out_ready;
    logic                        word_kind;
    logic [brle_pkg::CodeW-1:0]  code_value;
    logic                        final_word;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [brle_pkg::GammaW-1:0] gamma_bits;

    // encoder state as the testbench sees it
    logic [brle_pkg::GammaW-1:0] gamma_cfg;
    logic                        run_bit;
    int unsigned                 run_len;
    logic                        in_stream;

    brle_pkg::word_t             word_q[$];
    row_t                        directed[25];
    logic [brle_pkg::GammaW-1:0] gamma_plan[8] =
        '{5'd1, 5'd2, 5'd3, 5'd4, 5'd0, 5'd8, 5'd16, 5'd31};

    logic              calm;
    logic              hold_req;
    int                hold_left;
    int                errors;
    int                beats_in;
    int                words_out;
    int                cfg_writes;
    int                cycles;

    binary_run_length_encoder i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .bit_value     (bit_value),
        .end_of_stream (end_of_stream),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .word_kind     (word_kind),
        .code_value    (code_value),
        .final_word    (final_word),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .gamma_bits    (gamma_bits)
    );

    initial clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles >= CycleLimit)
        begin
            $display("%0t: timeout, %0d words still due", $time, word_q.size());
            $display("tb_binary_run_length_encoder failed");
            $finish;
        end
    end

    function automatic int unsigned code_max(input logic [brle_pkg::GammaW-1:0] g);
        int unsigned w;
        w = g;
        if (w < 1)
            w = 1;
        if (w > MaxGamma)
            w = MaxGamma;
        return (32'd1 << w) - 1;
    endfunction

    function automatic brle_pkg::word_t wd(input logic kind, input int unsigned v,
                                           input logic last);
        brle_pkg::word_t w;
        w.kind  = kind;
        w.value = brle_pkg::CodeW'(v);
        w.last  = last;
        return w;
    endfunction

    function automatic brle_pkg::rec_t want_of(input int n, input brle_pkg::word_t w0,
                                               input brle_pkg::word_t w1,
                                               input brle_pkg::word_t w2);
        brle_pkg::rec_t r;
        r.count    = 2'(n);
        r.words[0] = w0;
        r.words[1] = w1;
        r.words[2] = w2;
        return r;
    endfunction

    function automatic row_t row(input int g, input logic bv, input logic eos,
                                 input brle_pkg::rec_t want);
        row_t r;
        r.gamma = brle_pkg::GammaW'(g);
        r.bv    = bv;
        r.eos   = eos;
        r.want  = want;
        return r;
    endfunction

    function automatic void add_word(inout brle_pkg::rec_t r, input logic kind,
                                     input int unsigned v, input logic last);
        r.words[r.count] = wd(kind, v, last);
        r.count          = r.count + 2'd1;
    endfunction

    // words produced by one bit beat; updates the run state
    function automatic brle_pkg::rec_t encode_bit(input logic b, input logic e);
        brle_pkg::rec_t r;
        int unsigned    m;
        r = '0;
        m = code_max(gamma_cfg);
        if (!in_stream)
        begin
            add_word(r, Hdr, b, 1'b0);
            in_stream = 1'b1;
            run_bit   = b;
            run_len   = 1;
        end
        else if (b == run_bit)
        begin
            if (run_len >= m)
            begin
                add_word(r, Run, m, 1'b0);
                add_word(r, Run, 0, 1'b0);
                run_len = 1;
            end
            else
                run_len++;
        end
        else
        begin
            add_word(r, Run, (run_len > m) ? m : run_len, 1'b0);
            run_bit = b;
            run_len = 1;
        end
        if (e)
        begin
            add_word(r, Run, (run_len > m) ? m : run_len, 1'b1);
            in_stream = 1'b0;
            run_bit   = 1'b0;
            run_len   = 0;
        end
        return r;
    endfunction

    task automatic send_item(input logic b, input logic e, input brle_pkg::rec_t want);
        brle_pkg::rec_t got;
        @(negedge clk);
        if (!calm && $urandom_range(0, 99) < IdlePct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid      <= 1'b1;
        bit_value     <= b;
        end_of_stream <= e;
        do @(posedge clk); while (!in_ready);
        got = encode_bit(b, e);
        if (want.count != 0)
            got = want;
        for (int i = 0; i < got.count; i++)
            word_q.push_back(got.words[i]);
        beats_in++;
    endtask

    // only written with nothing in flight
    task automatic set_gamma(input logic [brle_pkg::GammaW-1:0] g);
        @(negedge clk);
        in_valid <= 1'b0;
        while (word_q.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        @(negedge clk);
        cfg_valid  <= 1'b1;
        gamma_bits <= g;
        do @(posedge clk); while (!cfg_ready);
        gamma_cfg = g;
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // output side
    initial
    begin
        brle_pkg::word_t due;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left != 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HoldCycles - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= calm || ($urandom_range(0, 99) >= IdlePct);
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                words_out++;
                if (word_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: expected no word, got kind %0d value %0d final %0d",
                             $time, word_kind, code_value, final_word);
                end
                else
                begin
                    due = word_q.pop_front();
                    if ({word_kind, code_value, final_word} !== due)
                    begin
                        errors++;
                        $display("%0t: expected kind %0d value %0d final %0d,",
                                 $time, due.kind, due.value, due.last);
                        $display("%0t: got kind %0d value %0d final %0d",
                                 $time, word_kind, code_value, final_word);
                    end
                end
            end
        end
    end

    // input side and sequencing
    initial
    begin
        logic [brle_pkg::GammaW-1:0] g;
        int unsigned                 m;
        int unsigned                 len;
        int                          n;
        logic                        rb;
        logic                        b;
        logic                        e;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        bit_value     = 1'b0;
        end_of_stream = 1'b0;
        cfg_valid     = 1'b0;
        gamma_bits    = '0;
        gamma_cfg     = brle_pkg::GammaW'(brle_pkg::GammaReset);
        run_bit       = 1'b0;
        run_len       = 0;
        in_stream     = 1'b0;
        calm          = 1'b0;
        hold_req      = 1'b0;
        hold_left     = 0;
        errors        = 0;
        beats_in      = 0;
        words_out     = 0;
        cfg_writes    = 0;
        cycles        = 0;
        rb            = 1'b0;

        // single bit at reset width, escapes and exact maximum at width 2,
        // width changes mid-stream (0 acts as 1, saturation), width above 16
        directed[0]  = row(8, 1'b1, 1'b1, want_of(2, wd(Hdr, 1, 1'b0), wd(Run, 1, 1'b1), NoWord));
        directed[1]  = row(2, 1'b0, 1'b0, want_of(1, wd(Hdr, 0, 1'b0), NoWord, NoWord));
        directed[2]  = row(2, 1'b0, 1'b0, '0);
        directed[3]  = row(2, 1'b0, 1'b0, '0);
        directed[4]  = row(2, 1'b0, 1'b0, want_of(2, wd(Run, 3, 1'b0), wd(Run, 0, 1'b0), NoWord));
        directed[5]  = row(2, 1'b0, 1'b0, '0);
        directed[6]  = row(2, 1'b1, 1'b0, '0);
        directed[7]  = row(2, 1'b1, 1'b1, '0);
        directed[8]  = row(2, 1'b1, 1'b0, want_of(1, wd(Hdr, 1, 1'b0), NoWord, NoWord));
        directed[9]  = row(2, 1'b1, 1'b0, '0);
        directed[10] = row(2, 1'b1, 1'b0, '0);
        directed[11] = row(2, 1'b0, 1'b0, want_of(1, wd(Run, 3, 1'b0), NoWord, NoWord));
        directed[12] = row(2, 1'b0, 1'b1, want_of(1, wd(Run, 2, 1'b1), NoWord, NoWord));
        directed[13] = row(2, 1'b0, 1'b0, want_of(1, wd(Hdr, 0, 1'b0), NoWord, NoWord));
        directed[14] = row(2, 1'b0, 1'b0, '0);
        directed[15] = row(2, 1'b0, 1'b0, '0);
        directed[16] = row(0, 1'b0, 1'b0, '0);
        directed[17] = row(0, 1'b1, 1'b0, '0);
        directed[18] = row(0, 1'b1, 1'b1, want_of(3, wd(Run, 1, 1'b0), wd(Run, 0, 1'b0),
                                                  wd(Run, 1, 1'b1)));
        directed[19] = row(3, 1'b1, 1'b0, '0);
        directed[20] = row(3, 1'b1, 1'b0, '0);
        directed[21] = row(3, 1'b1, 1'b0, '0);
        directed[22] = row(3, 1'b1, 1'b0, '0);
        directed[23] = row(1, 1'b0, 1'b1, '0);
        directed[24] = row(31, 1'b1, 1'b1, want_of(2, wd(Hdr, 1, 1'b0), wd(Run, 1, 1'b1), NoWord));

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
        begin
            if (directed[i].gamma != gamma_cfg)
                set_gamma(directed[i].gamma);
            send_item(directed[i].bv, directed[i].eos, directed[i].want);
        end

        // random runs, sized around the maximum code for narrow widths
        for (int p = 0; p < RandPhases; p++)
        begin
            g = (p < 8) ? gamma_plan[p] : brle_pkg::GammaW'($urandom_range(0, 31));
            if (g != gamma_cfg)
                set_gamma(g);
            calm = (p == 1);
            if (p == 0)
                hold_req = 1'b1;
            m = code_max(g);
            n = 0;
            while (n < PhaseBeats)
            begin
                if (m <= 15)
                    len = $urandom_range(1, 2 * m + 2);
                else if ($urandom_range(0, 3) == 0)
                    len = $urandom_range(1, 200);
                else
                    len = $urandom_range(1, 8);
                rb = ~rb;
                for (int k = 0; k < len && n < PhaseBeats; k++)
                begin
                    b = ($urandom_range(0, 99) < 6) ? 1'($urandom_range(0, 1)) : rb;
                    e = ($urandom_range(0, 29) == 0);
                    send_item(b, e, '0);
                    n++;
                end
            end
        end
        calm = 1'b0;

        @(negedge clk);
        in_valid <= 1'b0;
        while (word_q.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        $display("Covered %0d bit beats under %0d width writes: escapes, exact maxima,",
                 beats_in, cfg_writes);
        $display("widths 0 to 31, mid-stream width changes, a long output hold; %0d words, %0d bad.",
                 words_out, errors);
        if (errors == 0)
            $display("tb_binary_run_length_encoder passed");
        else
            $display("tb_binary_run_length_encoder failed");
        $finish;
    end

endmodule

### filelist.f
rtl/brle_pkg.sv
rtl/brle_front.sv
rtl/brle_fifo.sv
rtl/brle_back.sv
rtl/binary_run_length_encoder.sv
rtl/brle_checker.sv
sim/tb_binary_run_length_encoder.sv
